[sv/bcnp_pkg.sv]
// Shared types and constants for the bounding-box center nearest-point block.
// Holds the controller state encoding, the command and status bundles and the
// fixed widths of the result fields. Depends on nothing.
package bcnp_pkg;

   // Fixed widths of the result fields.
   localparam int IDX_OUT_W   = 10;
   localparam int COORD_OUT_W = 16;
   localparam int HALF_OUT_W  = 15;
   localparam int RSP_FIELD_W = IDX_OUT_W + 3 * COORD_OUT_W + HALF_OUT_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - RSP_FIELD_W;

   // Controller states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXTENT,
      ST_BOUND,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;        // take in the point on the request bus
      logic calc_extent;  // register per-axis extents
      logic calc_bound;   // register centers and the starting bound
      logic scan_step;    // issue one store read in the search pass
      logic emit;         // load the result register and clear the set
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_end;     // every stored point has been issued
      logic pipe_busy;    // distance pipeline still holds points
      logic out_free;     // result register can take a new result
   } status_type;

endpackage

[sv/bcnp_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the point store. Depends on nothing.
module bcnp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[sv/bcnp_datapath.sv]
// Datapath: point store, per-axis bounds, distance pipeline, best-point
// tracking and the result register. Depends on bcnp_pkg and bcnp_ram.
module bcnp_datapath #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bcnp_pkg::cmd_type                      cmd,
   output bcnp_pkg::status_type                   status,
   input  logic signed [COORD_BITS-1:0]           coord_x,
   input  logic signed [COORD_BITS-1:0]           coord_y,
   input  logic signed [COORD_BITS-1:0]           coord_z,
   input  logic                                   rsp_tready,
   output logic                                   rsp_valid,
   output logic [bcnp_pkg::IDX_OUT_W-1:0]         center_index,
   output logic signed [bcnp_pkg::COORD_OUT_W-1:0] center_x,
   output logic signed [bcnp_pkg::COORD_OUT_W-1:0] center_y,
   output logic signed [bcnp_pkg::COORD_OUT_W-1:0] center_z,
   output logic [bcnp_pkg::HALF_OUT_W-1:0]        half_extent,
   output logic                                   overflow
);
   import bcnp_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int IDX_W  = $clog2(MAX_POINTS);
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int EXT_W  = C + 1;
   localparam int SQ_W   = 2 * EXT_W;
   localparam int DIST_W = (SQ_W + 2 > 64) ? 64 : SQ_W + 2;
   localparam int PT_W   = 3 * C;

   // Set bookkeeping.
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic signed [C-1:0]   min_ff [0:2];
   logic signed [C-1:0]   max_ff [0:2];
   logic signed [C-1:0]   pt_in  [0:2];
   logic                  store_full;
   logic                  wr_en;

   // Extent, center and bound.
   logic [EXT_W-1:0]      ext_ff [0:2];
   logic signed [C-1:0]   ctr_ff [0:2];
   logic [SQ_W-1:0]       bound_prod;

   // Search pass.
   logic [CNT_W-1:0]      scan_ptr_ff;
   logic [PT_W-1:0]       rd_data;
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IDX_W-1:0]      idx1_ff, idx2_ff, idx3_ff, idx4_ff;
   logic [PT_W-1:0]       pt2_ff, pt3_ff, pt4_ff;
   logic [EXT_W-1:0]      abs_ff [0:2];
   logic [EXT_W-1:0]      abs_in [0:2];
   logic [SQ_W-1:0]       prod   [0:2];
   logic [DIST_W-1:0]     sq_ff  [0:2];
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic signed [EXT_W-1:0] diff [0:2];

   // Best point so far.
   logic [DIST_W-1:0]     best_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [PT_W-1:0]       best_pt_ff;
   logic                  better;

   // Result register.
   logic                  rsp_valid_ff;

   assign pt_in[0]   = coord_x;
   assign pt_in[1]   = coord_y;
   assign pt_in[2]   = coord_z;
   assign store_full = (count_ff == CNT_W'(MAX_POINTS));
   assign wr_en      = cmd.store && !store_full;

   // Point count and dropped flag; both clear when a result is emitted.
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.emit) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end else if (cmd.store) begin
         if (store_full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // Per-axis bounds; the first stored point of a set loads them.
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (wr_en) begin
            if (count_ff == '0 || pt_in[a] < min_ff[a]) begin
               min_ff[a] <= pt_in[a];
            end
            if (count_ff == '0 || pt_in[a] > max_ff[a]) begin
               max_ff[a] <= pt_in[a];
            end
         end
      end
   end

   // Point store.
   bcnp_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({coord_z, coord_y, coord_x}),
      .rd_en   (cmd.scan_step),
      .rd_addr (scan_ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Extents, then centers and the starting bound in the next cycle.
   assign bound_prod = ext_ff[0] * ext_ff[0];

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (cmd.calc_extent) begin
            ext_ff[a] <= EXT_W'(max_ff[a]) - EXT_W'(min_ff[a]);
         end
         if (cmd.calc_bound) begin
            ctr_ff[a] <= C'(EXT_W'(min_ff[a]) + (ext_ff[a] >> 1));
         end
      end
   end

   // Read pointer of the search pass.
   always_ff @(posedge clock) begin
      if (cmd.calc_bound) begin
         scan_ptr_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ptr_ff <= scan_ptr_ff + CNT_W'(1);
      end
   end

   // Stage one: absolute per-axis differences to the center.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         diff[a]   = EXT_W'($signed(rd_data[a*C +: C])) - EXT_W'(ctr_ff[a]);
         abs_in[a] = diff[a][EXT_W-1] ? EXT_W'(-diff[a]) : EXT_W'(diff[a]);
      end
   end

   // Stage two squares, stage three sums.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         prod[a] = abs_ff[a] * abs_ff[a];
      end
      dist_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // Distance pipeline payload.
   always_ff @(posedge clock) begin
      idx1_ff <= scan_ptr_ff[IDX_W-1:0];
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      pt2_ff  <= rd_data;
      pt3_ff  <= pt2_ff;
      pt4_ff  <= pt3_ff;
      for (int a = 0; a < 3; a++) begin
         abs_ff[a] <= abs_in[a];
         sq_ff[a]  <= DIST_W'(prod[a]);
      end
      dist_ff <= dist_in;
   end

   // Distance pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.scan_step;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage four: strict compare keeps the earliest of equal distances.
   // Entry zero always loads its position so it stands when nothing wins.
   assign better = dist_ff < best_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_bound) begin
         best_ff     <= DIST_W'(bound_prod);
         best_idx_ff <= '0;
      end else if (v4_ff) begin
         if (better) begin
            best_ff     <= dist_ff;
            best_idx_ff <= idx4_ff;
         end
         if (better || idx4_ff == '0) begin
            best_pt_ff <= pt4_ff;
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         center_index <= IDX_OUT_W'(best_idx_ff);
         center_x     <= COORD_OUT_W'($signed(best_pt_ff[0 +: C]));
         center_y     <= COORD_OUT_W'($signed(best_pt_ff[C +: C]));
         center_z     <= COORD_OUT_W'($signed(best_pt_ff[2*C +: C]));
         half_extent  <= HALF_OUT_W'(ext_ff[0] >> 1);
         overflow     <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign status.scan_end  = (scan_ptr_ff == count_ff);
   assign status.pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

[sv/bcnp_ctrl.sv]
// Controller state machine: loads points, sequences the extent, bound and
// search steps, and hands the result to the datapath. Depends on bcnp_pkg.
module bcnp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  bcnp_pkg::status_type status,
   output bcnp_pkg::cmd_type    cmd
);
   import bcnp_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            cmd.store  = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_EXTENT;
            end
         end
         ST_EXTENT: begin
            cmd.calc_extent = 1'b1;
            state_in        = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.calc_bound = 1'b1;
            state_in       = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_end) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

[sv/bbox_center_nearest_point.sv]
// Top level of the bounding-box center nearest-point block.
// Depends on bcnp_pkg, bcnp_ctrl, bcnp_datapath and bcnp_ram.
//
// Points arrive one per cycle on the request stream while the block is
// loading and are written to the point store while the per-axis bounds are
// tracked; a point that finds the store full is dropped and flagged. The
// transaction with tlast set closes the set: the block then forms the box
// center, takes the squared x extent as the starting bound and reads every
// stored point once through a distance pipeline fed by the store's single
// read port. No point is accepted during the search, nor until the result
// has been loaded into the output register. The result waits there, so the
// next set may start loading while it is still held.
module bbox_center_nearest_point #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request tdata, from bit 0 up: coord_x, coord_y, coord_z, zero fill.
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]         req_tdata,
   input  logic                                      req_tlast,  // last_point
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // Response tdata, from bit 0 up: center_index, center_x, center_y,
   // center_z, half_extent, overflow, zero fill.
   output logic [bcnp_pkg::RSP_DATA_W-1:0]           rsp_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready
);
   import bcnp_pkg::*;

   localparam int C = COORD_BITS;

   cmd_type                     cmd;
   status_type                  status;
   logic [IDX_OUT_W-1:0]        center_index;
   logic signed [COORD_OUT_W-1:0] center_x, center_y, center_z;
   logic [HALF_OUT_W-1:0]       half_extent;
   logic                        overflow;

   bcnp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bcnp_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .coord_x      ($signed(req_tdata[0 +: C])),
      .coord_y      ($signed(req_tdata[C +: C])),
      .coord_z      ($signed(req_tdata[2*C +: C])),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .center_index (center_index),
      .center_x     (center_x),
      .center_y     (center_y),
      .center_z     (center_z),
      .half_extent  (half_extent),
      .overflow     (overflow)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, overflow, half_extent, center_z,
                       center_y, center_x, center_index};

endmodule

[test/bbox_center_nearest_point_checker.sv]
`timescale 1ns / 1ps
// Checker for the bounding-box center nearest-point block: it watches both streams,
// predicts each result from the points it sees accepted and compares field by field.
// Depends on bcnp_pkg for the result field widths.
module bbox_center_nearest_point_checker #(
   parameter int MAX_POINTS = 1024,
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request tdata, from bit 0 up: coord_x, coord_y, coord_z, zero fill.
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   input  logic                                req_tlast,  // last_point
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // Response tdata, from bit 0 up: center_index, center_x, center_y,
   // center_z, half_extent, overflow, zero fill.
   input  logic [bcnp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output int                                  mismatches,
   output int                                  results_owed
);
   import bcnp_pkg::*;

   localparam int CW = COORD_OUT_W;

   // One result, declared from the top bit down so that it overlays tdata.
   typedef struct packed {
      logic                   overflow;
      logic [HALF_OUT_W-1:0]  half_extent;
      logic signed [CW-1:0]   z;
      logic signed [CW-1:0]   y;
      logic signed [CW-1:0]   x;
      logic [IDX_OUT_W-1:0]   index;
   } nearest_type;

   // Shadow copy of the block's point set.
   logic signed [CW-1:0] stored_pts [MAX_POINTS][3];
   int unsigned          stored_count;
   logic signed [CW-1:0] axis_lo [3];
   logic signed [CW-1:0] axis_hi [3];
   logic                 points_dropped;
   nearest_type          expected_nearest [$];

   // Take in one accepted point; on the closing point, search for the nearest one.
   task automatic take_point(input logic signed [CW-1:0] px, py, pz, input logic is_last);
      logic signed [CW-1:0] pt [3];
      int                   center [3];
      int                   ext;
      longint               best;
      longint               sq_sum;
      longint               d;
      int                   pick;
      nearest_type          res;
      pt[0] = px;
      pt[1] = py;
      pt[2] = pz;
      if (stored_count < MAX_POINTS) begin
         for (int a = 0; a < 3; a++) begin
            stored_pts[stored_count][a] = pt[a];
            if (stored_count == 0 || pt[a] < axis_lo[a]) axis_lo[a] = pt[a];
            if (stored_count == 0 || pt[a] > axis_hi[a]) axis_hi[a] = pt[a];
         end
         stored_count++;
      end else begin
         points_dropped = 1'b1;
      end
      if (!is_last) return;

      // Box center per axis, rounded down; the squared x extent is the first bound.
      for (int a = 0; a < 3; a++) begin
         ext = int'(axis_hi[a]) - int'(axis_lo[a]);
         center[a] = int'(axis_lo[a]) + (ext >>> 1);
      end
      ext = int'(axis_hi[0]) - int'(axis_lo[0]);
      best = longint'(ext) * longint'(ext);
      pick = 0;

      // Strict less-than keeps the earliest of equally near points.
      for (int i = 0; i < int'(stored_count); i++) begin
         sq_sum = 0;
         for (int a = 0; a < 3; a++) begin
            d = longint'(stored_pts[i][a]) - longint'(center[a]);
            sq_sum += d * d;
         end
         if (sq_sum < best) begin
            best = sq_sum;
            pick = i;
         end
      end

      res.index       = IDX_OUT_W'(pick);
      res.x           = stored_pts[pick][0];
      res.y           = stored_pts[pick][1];
      res.z           = stored_pts[pick][2];
      res.half_extent = HALF_OUT_W'(ext >>> 1);
      res.overflow    = points_dropped;
      expected_nearest.push_back(res);
      stored_count   = 0;
      points_dropped = 1'b0;
   endtask

   // Compare one delivered result with the oldest expectation.
   task automatic check_result(input logic [RSP_DATA_W-1:0] data);
      nearest_type got;
      nearest_type want;
      got = nearest_type'(data[RSP_FIELD_W-1:0]);
      if (expected_nearest.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result with none expected: index %0d x %0d y %0d z %0d",
                     $realtime, got.index, got.x, got.y, got.z);
         return;
      end
      want = expected_nearest.pop_front();
      if (got.index !== want.index || got.x !== want.x || got.y !== want.y ||
          got.z !== want.z || got.half_extent !== want.half_extent ||
          got.overflow !== want.overflow) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch, expected index %0d x %0d y %0d z %0d half %0d ovf %0b",
                     $realtime, want.index, want.x, want.y, want.z, want.half_extent,
                     want.overflow);
            $display("%0t:           actual index %0d x %0d y %0d z %0d half %0d ovf %0b",
                     $realtime, got.index, got.x, got.y, got.z, got.half_extent,
                     got.overflow);
         end
      end
   endtask

   initial begin
      mismatches = 0;
      results_owed = 0;
   end

   // Results are checked before new points go in, so an edge carrying both is safe.
   always @(posedge clock) begin
      if (reset) begin
         stored_count   = 0;
         points_dropped = 1'b0;
         expected_nearest.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tdata);
         if (req_tvalid && req_tready)
            take_point(req_tdata[CW-1:0], req_tdata[2*CW-1:CW], req_tdata[3*CW-1:2*CW],
                       req_tlast);
      end
      results_owed <= expected_nearest.size();
   end

endmodule

[test/bbox_center_nearest_point_test.sv]
`timescale 1ns / 1ps
// Testbench top for the bounding-box center nearest-point block: makes point sets,
// drives and drains the streams and gives the verdict. Depends on bcnp_pkg, the
// block itself and bbox_center_nearest_point_checker.
module bbox_center_nearest_point_test;
   import bcnp_pkg::*;

   localparam int MAX_POINTS = 1024;
   localparam int COORD_BITS = 16;
   localparam int REQ_W      = ((3 * COORD_BITS + 7) / 8) * 8;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_W-1:0]      req_tdata;   // from bit 0 up: coord_x, coord_y, coord_z
   logic                  req_tlast;   // last_point
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // index, x, y, z, half_extent, overflow
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   int                    mismatches;
   int                    results_owed;
   int                    burst_left = 1;

   bbox_center_nearest_point #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   bbox_center_nearest_point_checker #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS)
   ) checker_inst (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .mismatches(mismatches),
      .results_owed(results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one point until it is taken; bursts end in a random gap, often none.
   task automatic send_point(input logic [15:0] x, y, z, input logic is_last);
      int gap;
      req_tdata  <= {z, y, x};
      req_tlast  <= is_last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Hold the sender back until every predicted result has been delivered.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   // One coordinate in the flavor of the current set.
   function automatic logic [15:0] pick_coord(input int style, input logic [15:0] base);
      case (style)
         0: return 16'($urandom);
         1: return base + 16'($urandom_range(0, 15)) - 16'd8;
         2: begin
            case ($urandom_range(0, 3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
         // A coarse symmetric grid around the base gives many equal distances.
         default: return base + 16'($urandom_range(0, 4) * 2) - 16'd4;
      endcase
   endfunction

   // One set of points, the last one closing it.
   task automatic send_set(input int count, input int style);
      logic [15:0] base [3];
      for (int a = 0; a < 3; a++) base[a] = 16'($urandom);
      for (int i = 0; i < count; i++)
         send_point(pick_coord(style, base[0]), pick_coord(style, base[1]),
                    pick_coord(style, base[2]), i == count - 1);
   endtask

   // Receiver: a rotating ready pattern, plus one long hold-off after some results.
   initial begin : receiver
      int cyc;
      int taken;
      int hold;
      bit long_done;
      cyc = 0;
      taken = 0;
      hold = 0;
      long_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         cyc++;
         if (taken == 30 && !long_done) begin
            hold = 400;
            long_done = 1;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            case ((cyc / 97) % 4)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= (cyc % 5) == 0;
               default: rsp_tready <= $urandom_range(0, 7) != 0;
            endcase
         end
      end
   end

   // Stimulus and verdict.
   initial begin : stimulus
      int sent;
      int count;
      int r;
      bit overflow_done;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A single point at the coordinate extremes.
      send_point(16'(32767), 16'(-32768), 16'(0), 1'b1);
      // Two opposite corners: the widest possible extent.
      send_point(16'(-32768), 16'(-32768), 16'(-32768), 1'b0);
      send_point(16'(32767), 16'(32767), 16'(32767), 1'b1);
      // Equal distances: the earlier of the two nearest points wins.
      send_point(16'(0), 16'(0), 16'(0), 1'b0);
      send_point(16'(8), 16'(0), 16'(0), 1'b0);
      send_point(16'(3), 16'(0), 16'(0), 1'b0);
      send_point(16'(5), 16'(0), 16'(0), 1'b1);
      // Zero x extent: nothing beats the bound, so the first point is chosen.
      send_point(16'(5), 16'(-100), 16'(0), 1'b0);
      send_point(16'(5), 16'(100), 16'(0), 1'b0);
      send_point(16'(5), 16'(0), 16'(0), 1'b1);
      // Negative coordinates and odd extents round the center down.
      send_point(16'(-7), 16'(-1), 16'(20), 1'b0);
      send_point(16'(-2), 16'(-6), 16'(-21), 1'b0);
      send_point(16'(-4), 16'(-3), 16'(0), 1'b0);
      send_point(16'(-5), 16'(-4), 16'(1), 1'b1);
      // Repeated identical points.
      send_point(16'(-1), 16'(-1), 16'(-1), 1'b0);
      send_point(16'(-1), 16'(-1), 16'(-1), 1'b0);
      send_point(16'(-1), 16'(-1), 16'(-1), 1'b1);
      wait_for_results();

      // Random sets, mostly small, with one set that overruns the store.
      sent = 0;
      overflow_done = 0;
      while (sent < 1900) begin
         if (!overflow_done && sent >= 600) begin
            // Store full: the last three points, the closing one among them, are dropped.
            wait_for_results();
            send_set(MAX_POINTS + 3, $urandom_range(0, 3));
            sent += MAX_POINTS + 3;
            overflow_done = 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 80)      count = $urandom_range(1, 10);
            else if (r < 97) count = $urandom_range(11, 48);
            else             count = $urandom_range(49, 200);
            send_set(count, $urandom_range(0, 3));
            sent += count;
         end
      end

      wait_for_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && results_owed == 0)
         $display("bbox_center_nearest_point_test OK");
      else
         $display("bbox_center_nearest_point_test NOT OK");
      $finish;
   end

   // Guard against a hang anywhere in the run.
   initial begin : watchdog
      #5000000;
      $display("bbox_center_nearest_point_test NOT OK");
      $finish;
   end

endmodule

[filelist.f]
sv/bcnp_pkg.sv
sv/bcnp_ram.sv
sv/bcnp_datapath.sv
sv/bcnp_ctrl.sv
sv/bbox_center_nearest_point.sv
test/bbox_center_nearest_point_checker.sv
test/bbox_center_nearest_point_test.sv
